>>> rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int DATA_W      = 32;
    localparam int PRIO_W      = 16;
    localparam int COUNT_OUT_W = 5;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 80;

    localparam logic [DATA_W-1:0] EMPTY_MARK = {DATA_W{1'b1}};

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Operation broadcast to every cell of the chain in the cycle of a beat.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [DATA_W-1:0] item_data;
        logic [PRIO_W-1:0] item_priority;
    } cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts it toward either neighbor.
module spq_cell
(
    input  logic                       clk,
    input  spq_pkg::cell_ctrl_t        ctrl,
    input  logic                       occupied,
    input  logic                       left_stays,
    input  logic [spq_pkg::DATA_W-1:0] left_data,
    input  logic [spq_pkg::PRIO_W-1:0] left_prio,
    input  logic [spq_pkg::DATA_W-1:0] right_data,
    input  logic [spq_pkg::PRIO_W-1:0] right_prio,
    output logic                       stays,
    output logic [spq_pkg::DATA_W-1:0] data,
    output logic [spq_pkg::PRIO_W-1:0] prio,
    output logic [spq_pkg::DATA_W-1:0] data_next
);
    import spq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;

    // An entry of equal or smaller priority keeps its place on a push.
    assign stays = occupied && (prio_reg <= ctrl.item_priority);

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctrl.push && !stays)
        begin
            if (left_stays)
            begin
                data_next = ctrl.item_data;
                prio_next = ctrl.item_priority;
            end
            else
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
        end
        else if (ctrl.pop)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;

endmodule

>>> rtl/sorted_priority_queue_core.sv
// Sorted priority queue: a row of DEPTH cells kept in ascending priority order.
// Each beat on the input is one request: a push (tuser 0) places the entry behind every held
// entry of equal or smaller priority, a pop (tuser 1) removes the head. All cells compare the
// new priority and shift toward their neighbor in the same cycle, so a new request is accepted
// every cycle unless the output stalls; the result beat leaves from an output register
// in the cycle after the request and the input stalls only while that register waits to be
// taken. A push into a full queue is dropped and flagged, a pop of an empty queue returns -1.
module sorted_priority_queue_core
#(
    parameter int DEPTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // item_data [31:0], item_priority [47:32]
    input  logic [spq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // popped_data [31:0], pop_valid [32], pop_empty [33], push_dropped [34],
    // head_data [66:35], head_valid [67], entry_count [72:68], zero [79:73]
    output logic [spq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int RES_W = DATA_W + 3 + DATA_W + 1 + COUNT_OUT_W;

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic              accept;
    logic              req_pop;
    logic              full;
    logic              empty;
    logic [DATA_W-1:0] item_data;
    logic [PRIO_W-1:0] item_priority;
    cell_ctrl_t        ctrl;

    logic [DEPTH-1:0]  cell_stays;
    logic [DATA_W-1:0] cell_data      [DEPTH];
    logic [PRIO_W-1:0] cell_prio      [DEPTH];
    logic [DATA_W-1:0] cell_data_next [DEPTH];

    logic              pop_valid;
    logic              pop_empty;
    logic              push_dropped;
    logic [DATA_W-1:0] popped_data;
    logic [DATA_W-1:0] head_data;
    logic              head_valid;
    logic [COUNT_OUT_W-1:0] entry_count;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req_pop       = (s_axis_tuser == REQ_POP);
    assign item_data     = s_axis_tdata[DATA_W-1:0];
    assign item_priority = s_axis_tdata[DATA_W+PRIO_W-1:DATA_W];
    assign full          = (count_reg == CW'(DEPTH));
    assign empty         = (count_reg == '0);

    // Gate the shift so a dropped push or an empty pop leaves the chain untouched.
    always_comb
    begin
        ctrl.push          = accept && !req_pop && !full;
        ctrl.pop           = accept && req_pop && !empty;
        ctrl.item_data     = item_data;
        ctrl.item_priority = item_priority;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic              occ;
        logic              l_stays;
        logic [DATA_W-1:0] l_data;
        logic [PRIO_W-1:0] l_prio;
        logic [DATA_W-1:0] r_data;
        logic [PRIO_W-1:0] r_prio;

        assign occ = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign l_stays = 1'b1;
            assign l_data  = item_data;
            assign l_prio  = item_priority;
        end
        else
        begin : g_body
            assign l_stays = cell_stays[i-1];
            assign l_data  = cell_data[i-1];
            assign l_prio  = cell_prio[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_data = '0;
            assign r_prio = '0;
        end
        else
        begin : g_mid
            assign r_data = cell_data[i+1];
            assign r_prio = cell_prio[i+1];
        end

        spq_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ),
            .left_stays (l_stays),
            .left_data  (l_data),
            .left_prio  (l_prio),
            .right_data (r_data),
            .right_prio (r_prio),
            .stays      (cell_stays[i]),
            .data       (cell_data[i]),
            .prio       (cell_prio[i]),
            .data_next  (cell_data_next[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end

        pop_valid    = ctrl.pop;
        pop_empty    = accept && req_pop && empty;
        push_dropped = accept && !req_pop && full;
        popped_data  = '0;
        if (pop_valid)
        begin
            popped_data = cell_data[0];
        end
        else if (pop_empty)
        begin
            popped_data = EMPTY_MARK;
        end

        head_valid  = (count_next != '0);
        head_data   = head_valid ? cell_data_next[0] : EMPTY_MARK;
        entry_count = COUNT_OUT_W'(count_next);

        out_data_next = OUT_TDATA_W'({entry_count, head_valid, head_data,
                                      push_dropped, pop_empty, pop_valid, popped_data});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result beat until the sink takes it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    if (RES_W > OUT_TDATA_W)
    begin : g_width_check
        $error("result fields do not fit in m_axis_tdata");
    end

endmodule
